// File: rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps

package dq_pkg;

  // Default number of entries held by the queue.
  localparam int DEPTH_DEFAULT = 16;

  // Width of one stored value.
  localparam int DATA_W = 32;

  // Width of the occupancy field in a result.
  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } result_t;

  // Broadcast to every cell: which operation to apply this cycle.
  typedef struct packed {
    logic  en;
    kind_t kind;
  } cell_ctrl_t;

endpackage

// File: rtl/dq_cell.sv
// One storage cell of the queue row: a value, an occupied flag and the shift rules.
`timescale 1ns / 1ps

module dq_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  dq_pkg::cell_ctrl_t               ctrl,
  input  logic signed [dq_pkg::DATA_W-1:0] push_value,
  input  logic signed [dq_pkg::DATA_W-1:0] left_data,
  input  logic                             left_valid,
  input  logic signed [dq_pkg::DATA_W-1:0] right_data,
  input  logic                             right_valid,
  output logic signed [dq_pkg::DATA_W-1:0] data,
  output logic                             valid,
  output logic                             tail
);

  // This cell holds the rear entry when it is occupied and its right neighbor is not.
  assign tail = valid && !right_valid;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      unique case (ctrl.kind)
        dq_pkg::KIND_PUSH_FRONT: begin
          data <= left_data;
        end
        dq_pkg::KIND_PUSH_REAR: begin
          if (left_valid && !valid) begin
            data <= push_value;
          end
        end
        dq_pkg::KIND_POP_FRONT: begin
          data <= right_data;
        end
        dq_pkg::KIND_POP_REAR: begin
          data <= data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.en) begin
      unique case (ctrl.kind)
        dq_pkg::KIND_PUSH_FRONT: begin
          valid <= left_valid;
        end
        dq_pkg::KIND_PUSH_REAR: begin
          if (left_valid) begin
            valid <= 1'b1;
          end
        end
        dq_pkg::KIND_POP_FRONT: begin
          valid <= right_valid;
        end
        dq_pkg::KIND_POP_REAR: begin
          if (!right_valid) begin
            valid <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/double_ended_queue.sv
// Top level of the double-ended queue: a row of shifting cells plus result register.
`timescale 1ns / 1ps

// The queue takes one transaction in every clock cycle: busy is never raised,
// so a command is accepted at each rising edge where start is high. Its result
// appears on the result port in the next cycle, marked by done for that single
// cycle, and must be captured then because it cannot be held off. This comes
// from the cell row, where every cell updates in parallel from its
// neighbors, so a push or pop at either end is a single register update.
// Entries live in a row of DEPTH cells with the front entry always in cell 0.
// A front push shifts the row toward the rear, a front pop shifts it toward the
// front, and rear operations touch only the cell at the boundary between
// occupied and empty cells. A push onto a full queue or a pop from an empty one
// leaves the contents alone and reports full or empty in the status field.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dq_pkg::cmd_t     cmd,
  output logic             done,
  output dq_pkg::result_t  result
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [dq_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]                 valid;
  logic [DEPTH-1:0]                 tail;
  logic [CNT_W-1:0]                 cnt;
  logic [CNT_W-1:0]                 cnt_next;
  dq_pkg::cell_ctrl_t               ctrl;
  dq_pkg::result_t                  result_next;
  logic                             accept;
  logic                             is_push;
  logic                             full;
  logic                             empty;
  logic                             legal;
  logic signed [dq_pkg::DATA_W-1:0] rear_value;

  // The block never stalls a command.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Occupied cells always form a prefix of the row, so the ends tell all.
  assign full    = valid[DEPTH-1];
  assign empty   = !valid[0];
  assign is_push = (cmd.kind == dq_pkg::KIND_PUSH_FRONT) ||
                   (cmd.kind == dq_pkg::KIND_PUSH_REAR);
  assign legal   = is_push ? !full : !empty;

  assign ctrl.en   = accept && legal;
  assign ctrl.kind = cmd.kind;

  // The rear entry is picked out with the one-hot tail flags.
  always_comb begin
    rear_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tail[i]) begin
        rear_value = rear_value | cell_data[i];
      end
    end
  end

  // Cell 0 takes the pushed value from its left side on a front push; the last
  // cell sees an empty neighbor on its right so pops shift in nothing.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [dq_pkg::DATA_W-1:0] l_data;
    logic                             l_valid;
    logic signed [dq_pkg::DATA_W-1:0] r_data;
    logic                             r_valid;

    if (i == 0) begin : g_first
      assign l_data  = cmd.value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[i-1];
      assign l_valid = valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = cell_data[i+1];
      assign r_valid = valid[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .push_value  (cmd.value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (valid[i]),
      .tail        (tail[i])
    );
  end

  // Entry count and result for the command being accepted.
  always_comb begin
    cnt_next           = cnt;
    result_next.popped = '0;
    result_next.status = dq_pkg::ST_OK;
    if (!legal) begin
      result_next.status = is_push ? dq_pkg::ST_FULL : dq_pkg::ST_EMPTY;
    end else begin
      unique case (cmd.kind)
        dq_pkg::KIND_PUSH_FRONT,
        dq_pkg::KIND_PUSH_REAR: begin
          cnt_next = cnt + CNT_W'(1);
        end
        dq_pkg::KIND_POP_FRONT: begin
          cnt_next           = cnt - CNT_W'(1);
          result_next.popped = cell_data[0];
        end
        dq_pkg::KIND_POP_REAR: begin
          cnt_next           = cnt - CNT_W'(1);
          result_next.popped = rear_value;
        end
      endcase
    end
    result_next.occupancy = dq_pkg::OCC_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        cnt <= cnt_next;
      end
    end
  end

  // The result register carries no reset; done qualifies it.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Every accepted transaction yields a result in the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted transaction produced no result");

  // The entry count agrees with the number of occupied cells.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == cnt)
    else $error("entry count disagrees with occupied cells");

  // Occupied cells stay packed toward the front of the row.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid[DEPTH-1:1] & ~valid[DEPTH-2:0]) == '0)
    else $error("occupied cells are not contiguous from the front");

  // A failed pop reports an empty queue and a zero value.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == dq_pkg::ST_EMPTY) |->
      (result.occupancy == '0 && result.popped == '0))
    else $error("empty status with nonzero occupancy or value");

  // At most one cell is the rear entry.
  a_tail_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tail))
    else $error("more than one rear cell");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the double-ended queue: directed table, then biased random traffic.
`timescale 1ns / 1ps

// The bench drives one command transaction at a time on start/cmd and checks
// every result that done marks. A mirror of the queue, a ring with a head
// position and an entry count, runs beside the block. Each accepted command
// updates the mirror and leaves one expected result in a FIFO. Each result the
// block returns is compared, field by field, with the oldest entry there.
//
// Stimulus comes in two parts. A short table walks the corner cases: pops on
// an empty queue, the largest and smallest values, the head wrapping below
// position zero, the rear wrapping past the last slot, a full queue refusing
// pushes at both ends, and a pop from each end afterwards. Rows whose result
// is plain to see carry that result typed in. The other rows go through the
// mirror. Random traffic follows in segments that lean toward filling,
// draining or neither. This way the queue keeps hitting full and empty with
// random contents in between.
module tb;
  import dq_pkg::*;

  localparam int QDEPTH      = DEPTH_DEFAULT;
  localparam int RANDOM_OPS  = 1700;
  // The last stretch of random commands is sent back to back with no gaps.
  localparam int CALM_TAIL   = 300;
  // Cycles without any transaction in either direction before giving up.
  localparam int STALL_LIMIT = 500;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    LEAN_FILL,
    LEAN_DRAIN,
    LEAN_EVEN
  } lean_t;

  // One row of the directed table. When typed is set, want is the result to
  // check against. Otherwise the mirror supplies it.
  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
    logic [4:0]               reps;
    logic                     typed;
    result_t                  want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  logic    busy;
  logic    done;
  cmd_t    cmd;
  result_t result;

  // A typed-in expectation that travels with the command being offered.
  logic    fixed_due_valid;
  result_t fixed_due;

  // Mirror of the queue contents.
  logic signed [DATA_W-1:0] mirror_slots [QDEPTH];
  int mirror_head  = 0;
  int mirror_count = 0;

  // Results still owed by the block, oldest first.
  result_t op_results_due [$];

  int fail_count   = 0;
  int checked      = 0;
  int pops_with_data = 0;
  int full_refusals  = 0;
  int empty_refusals = 0;
  int idle_run     = 0;

  stim_row_t directed_rows [14];

  double_ended_queue #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one command to the mirror and returns the result it must produce.
  function automatic result_t predict_deque_op(input cmd_t c);
    result_t r;
    int      pos;
    r = '0;
    r.status = ST_OK;
    case (c.kind)
      KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
        if (mirror_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (c.kind == KIND_PUSH_FRONT) begin
            // The head steps back one slot, wrapping below zero.
            mirror_head = (mirror_head + QDEPTH - 1) % QDEPTH;
            pos = mirror_head;
          end else begin
            pos = (mirror_head + mirror_count) % QDEPTH;
          end
          mirror_slots[pos] = c.value;
          mirror_count++;
        end
      end
      default: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (c.kind == KIND_POP_FRONT) begin
            pos = mirror_head;
            mirror_head = (mirror_head + 1) % QDEPTH;
          end else begin
            pos = (mirror_head + mirror_count - 1) % QDEPTH;
          end
          r.popped = mirror_slots[pos];
          mirror_count--;
        end
      end
    endcase
    r.occupancy = OCC_W'(mirror_count);
    return r;
  endfunction

  function automatic stim_row_t mk_row(input kind_t k, input logic [DATA_W-1:0] v,
                                       input int n, input logic t,
                                       input logic [DATA_W-1:0] p, input status_t s,
                                       input int occ);
    stim_row_t row;
    row.kind = k;
    row.value = v;
    row.reps = 5'(n);
    row.typed = t;
    row.want.popped = p;
    row.want.status = s;
    row.want.occupancy = OCC_W'(occ);
    return row;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  // Offers one command transaction and returns at the edge that accepts it.
  task automatic issue(input cmd_t c, input logic t, input result_t w);
    start <= 1'b1;
    cmd <= c;
    fixed_due_valid <= t;
    fixed_due <= w;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Holds the sender off until every outstanding result has been checked.
  // The FIFO is read at the falling edge, away from the edge that changes it.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (op_results_due.size() != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // Scoreboard. Acceptance is sampled before the edge updates anything, so
  // the expectation goes in first and a result in the same cycle still finds it.
  always @(posedge clk) begin
    result_t fresh;
    result_t due;
    if (!rst) begin
      if (start && !busy) begin
        fresh = predict_deque_op(cmd);
        op_results_due.push_back(fixed_due_valid ? fixed_due : fresh);
      end
      if (done) begin
        if (op_results_due.size() == 0) begin
          note_failure($sformatf("unexpected result: popped=%h status=%0d occupancy=%0d",
                                 result.popped, result.status, result.occupancy));
        end else begin
          due = op_results_due.pop_front();
          checked++;
          if (result.popped !== due.popped || result.status !== due.status ||
              result.occupancy !== due.occupancy) begin
            note_failure($sformatf({"result mismatch: expected popped=%h status=%0d ",
                                    "occupancy=%0d, got popped=%h status=%0d occupancy=%0d"},
                                   due.popped, due.status, due.occupancy,
                                   result.popped, result.status, result.occupancy));
          end
          if (due.status == ST_FULL) full_refusals++;
          if (due.status == ST_EMPTY) empty_refusals++;
          if (due.status == ST_OK && due.popped != 0) pops_with_data++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction either way means a hang.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run + 1 >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, op_results_due.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    cmd_t  c;
    int    seg_left;
    lean_t lean;
    bit    gaps_on;
    int    push_pct;
    bit    is_push;
    bit    is_front;

    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    fixed_due_valid = 1'b0;
    fixed_due = '0;
    seg_left = 0;
    lean = LEAN_EVEN;
    gaps_on = 1'b0;

    // Pops carry a nonzero value to show that the value field is ignored.
    directed_rows[0]  = mk_row(KIND_POP_FRONT,  32'hDEAD_BEEF, 1, 1, 0, ST_EMPTY, 0);
    directed_rows[1]  = mk_row(KIND_POP_REAR,   32'hDEAD_BEEF, 1, 1, 0, ST_EMPTY, 0);
    directed_rows[2]  = mk_row(KIND_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1, 0, ST_OK, 1);
    directed_rows[3]  = mk_row(KIND_PUSH_REAR,  32'h8000_0000, 1, 1, 0, ST_OK, 2);
    directed_rows[4]  = mk_row(KIND_POP_FRONT,  32'hDEAD_BEEF, 1, 1, 32'h7FFF_FFFF, ST_OK, 1);
    directed_rows[5]  = mk_row(KIND_POP_REAR,   32'hDEAD_BEEF, 1, 1, 32'h8000_0000, ST_OK, 0);
    // The head is back at slot zero; the next two rows wrap the ring at both ends.
    directed_rows[6]  = mk_row(KIND_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1, 0, ST_OK, 1);
    directed_rows[7]  = mk_row(KIND_PUSH_REAR,  32'h0000_0000, 1, 1, 0, ST_OK, 2);
    directed_rows[8]  = mk_row(KIND_PUSH_FRONT, 32'hA5A5_5A5A, 7, 0, 0, ST_OK, 0);
    directed_rows[9]  = mk_row(KIND_PUSH_REAR,  32'h5A5A_A5A5, 7, 0, 0, ST_OK, 0);
    // The queue is full here, so pushes at either end must be refused.
    directed_rows[10] = mk_row(KIND_PUSH_REAR,  32'h0BAD_F00D, 1, 1, 0, ST_FULL, QDEPTH);
    directed_rows[11] = mk_row(KIND_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1, 0, ST_FULL, QDEPTH);
    directed_rows[12] = mk_row(KIND_POP_REAR,   32'hDEAD_BEEF, 1, 1, 32'h5A5A_A5A5, ST_OK,
                               QDEPTH - 1);
    directed_rows[13] = mk_row(KIND_POP_FRONT,  32'hDEAD_BEEF, 1, 1, 32'hA5A5_5A5A, ST_OK,
                               QDEPTH - 2);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps) begin
        c.kind = directed_rows[r].kind;
        c.value = directed_rows[r].value;
        issue(c, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    for (int i = 0; i < RANDOM_OPS; i++) begin
      // Each segment leans toward filling, draining or neither. This keeps
      // the queue swinging between empty and full, so both refusals occur
      // often.
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 48);
        lean = lean_t'($urandom_range(0, 2));
        gaps_on = ($urandom_range(0, 2) != 0);
      end
      seg_left--;
      push_pct = (lean == LEAN_FILL) ? 85 : (lean == LEAN_DRAIN) ? 15 : 50;
      is_push = ($urandom_range(1, 100) <= push_pct);
      is_front = 1'($urandom_range(0, 1));
      if (is_push) begin
        c.kind = is_front ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
      end else begin
        c.kind = is_front ? KIND_POP_FRONT : KIND_POP_REAR;
      end
      case ($urandom_range(0, 7))
        0: c.value = 32'h7FFF_FFFF;
        1: c.value = 32'h8000_0000;
        2: c.value = 32'h0000_0000;
        3: c.value = 32'hFFFF_FFFF;
        4: c.value = $urandom_range(0, 255);
        default: c.value = $urandom;
      endcase

      // Halfway through, and now and then before the final stretch, the
      // sender waits for the queue's results to drain before going on.
      if (i == RANDOM_OPS / 2 ||
          (i < RANDOM_OPS - CALM_TAIL && $urandom_range(0, 199) == 0)) begin
        wait_drained();
      end else if (gaps_on && i < RANDOM_OPS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        idle_cycles($urandom_range(1, 6));
      end
      issue(c, 1'b0, '0);
    end

    wait_drained();
    // Keep clocking to catch any result the block adds after the last one.
    repeat (4) @(posedge clk);

    $display("Checked %0d results: %0d pops returned data, %0d pushes refused as full,",
             checked, pops_with_data, full_refusals);
    $display("%0d pops refused as empty; %0d failures in all.", empty_refusals, fail_count);
    if (fail_count == 0 && op_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
